>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros. They compile away under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> rtl/cbws_pkg.sv
// ---------------------------------------------------------------------------
// cbws_pkg
// Widths, limits and register indexes of the clamped box window sum unit.
// ---------------------------------------------------------------------------
package cbws_pkg;

  // Field size and derived widths
  localparam int MAX_FIELD  = 64;
  localparam int ADDR_W     = $clog2(MAX_FIELD);
  localparam int CNT_W      = $clog2(MAX_FIELD + 1);

  // Data widths
  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = 22;
  localparam int GAIN_W     = 16;
  localparam int RADIUS_W   = 6;
  localparam int PROD_W     = SUM_W + GAIN_W;
  localparam int OUT_W      = 32;
  localparam int GAIN_SHIFT = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Reset value of the gain: 1.0 in Q4.12
  localparam logic signed [GAIN_W-1:0] GAIN_RESET = GAIN_W'(4096);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RADIUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN          = 1'b1;

endpackage

>>> rtl/cbws_ram.sv
// ---------------------------------------------------------------------------
// cbws_ram
// Generic RAM: one write port, two read ports with registered read data.
// ---------------------------------------------------------------------------
module cbws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read ports, data held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

>>> rtl/clamped_box_window_sum_unit.sv
// ---------------------------------------------------------------------------
// clamped_box_window_sum_unit
// Loads a field of samples into a prefix-sum memory, then emits the gain
// scaled, clamped box window sum for every loaded position.
// ---------------------------------------------------------------------------
// Load: one sample per cycle unless stalled, prefix sum written to RAM in the same cycle.
// Emit: a field of n samples gives n results, one per cycle unless result_stall
//   holds them; each passes RAM read, subtract, multiply and output register.
//   Sample input is stalled while the n positions are issued to the prefix RAM
//   with two read ports, one position per cycle unless result_stall holds it.
// Reset: radius 0, gain 1.0, empty field; the prefix RAM is not cleared.
`include "assert_macros.svh"

module clamped_box_window_sum_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  // sample channel
  input  logic                                  sample_valid,
  output logic                                  sample_stall,
  input  logic signed [cbws_pkg::SAMPLE_W-1:0]  sample,
  input  logic                                  frame_end,
  // result channel
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic signed [cbws_pkg::OUT_W-1:0]     weighted_sum,
  output logic                                  last_out,
  // configuration write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [cbws_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cbws_pkg::CFG_DATA_W-1:0]       cfg_data
);

  import cbws_pkg::*;

  typedef enum logic {ST_LOAD, ST_EMIT} state_t;

  state_t                     state;
  logic [RADIUS_W-1:0]        window_radius;
  logic signed [GAIN_W-1:0]   gain;
  logic [CNT_W-1:0]           sample_count;
  logic signed [SUM_W-1:0]    running_total;
  logic [CNT_W-1:0]           field_len;
  logic [ADDR_W-1:0]          pos;

  logic                       sample_acc;
  logic                       frame_close;
  logic signed [SUM_W-1:0]    total_next;
  logic                       adv;
  logic                       issue;
  logic [CNT_W-1:0]           right_full;
  logic [CNT_W-1:0]           last_pos;
  logic [ADDR_W-1:0]          right_addr;
  logic [ADDR_W-1:0]          left_addr;
  logic                       use_left;
  logic                       is_last;
  logic [SUM_W-1:0]           rd_right;
  logic [SUM_W-1:0]           rd_left;

  // pipeline stage registers
  logic                       v1, v2, v3;
  logic                       use_left1, last1, last2, last3;
  logic signed [SUM_W-1:0]    sum2;
  logic signed [PROD_W-1:0]   prod3;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_radius <= '0;
      gain          <= GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WINDOW_RADIUS: window_radius <= cfg_data[RADIUS_W-1:0];
        REG_GAIN:          gain          <= $signed(cfg_data[GAIN_W-1:0]);
        default: ;
      endcase
    end
  end

  // Load side
  assign sample_stall = (state == ST_EMIT);
  assign sample_acc   = sample_valid && !sample_stall;
  assign frame_close  = frame_end || (sample_count == CNT_W'(MAX_FIELD - 1));
  assign total_next   = running_total + SUM_W'(sample);

  // Emit side addressing: window clamped to [0, field_len-1]
  assign adv        = !result_valid || !result_stall;
  assign issue      = (state == ST_EMIT) && adv;
  assign right_full = CNT_W'(pos) + CNT_W'(window_radius);
  assign last_pos   = field_len - CNT_W'(1);
  assign right_addr = (right_full > last_pos) ? last_pos[ADDR_W-1:0]
                                              : right_full[ADDR_W-1:0];
  assign use_left   = pos > window_radius;
  assign left_addr  = pos - window_radius - ADDR_W'(1);
  assign is_last    = (CNT_W'(pos) == last_pos);

  // Prefix-sum memory
  cbws_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_FIELD)
  ) u_prefix_ram (
    .clk     (clk),
    .we      (sample_acc),
    .waddr   (sample_count[ADDR_W-1:0]),
    .wdata   (total_next),
    .re      (issue),
    .raddr_a (right_addr),
    .raddr_b (left_addr),
    .rdata_a (rd_right),
    .rdata_b (rd_left)
  );

  // Sequencer: load then emit
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      sample_count  <= '0;
      running_total <= '0;
      field_len     <= '0;
      pos           <= '0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (sample_acc) begin
            if (frame_close) begin
              field_len     <= sample_count + CNT_W'(1);
              sample_count  <= '0;
              running_total <= '0;
              pos           <= '0;
              state         <= ST_EMIT;
            end else begin
              sample_count  <= sample_count + CNT_W'(1);
              running_total <= total_next;
            end
          end
        end
        ST_EMIT: begin
          if (issue) begin
            pos <= pos + ADDR_W'(1);
            if (is_last) begin
              state <= ST_LOAD;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  // Result pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      v1           <= issue;
      v2           <= v1;
      v3           <= v2;
      result_valid <= v3;
    end
  end

  // Result pipeline payload: window sum, product, shift
  always_ff @(posedge clk) begin
    if (adv) begin
      if (issue) begin
        use_left1 <= use_left;
        last1     <= is_last;
      end
      sum2  <= $signed(rd_right) - (use_left1 ? $signed(rd_left) : SUM_W'(0));
      last2 <= last1;
      prod3 <= PROD_W'(sum2) * PROD_W'(gain);
      last3 <= last2;
      // floor shift; the shifted product always fits 32 bits
      weighted_sum <= OUT_W'(prod3 >>> GAIN_SHIFT);
      last_out     <= last3;
    end
  end

  // Assertions
  `ASSERT_NEXT(a_close_enters_emit, clk, rst, sample_acc && frame_close, state == ST_EMIT)
  `ASSERT_IMPL(a_right_in_field, clk, rst, issue, CNT_W'(right_addr) < field_len)
  `ASSERT_IMPL(a_count_in_range, clk, rst, 1'b1, sample_count < CNT_W'(MAX_FIELD))
  `ASSERT_IMPL(a_left_below_right, clk, rst, issue && use_left, left_addr < right_addr)

endmodule
